// ===== src/fsip_pkg.sv =====
package fsip_pkg;

    localparam int CHAR_W     = 8;
    localparam int ARG_W      = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IDX_W      = $clog2(BCD_DIGITS);
    localparam int STEP_W     = $clog2(ARG_W);

    // character codes
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_XL    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_XU    = 8'h58;

    typedef logic [BCD_W-1:0] t_digits;

    // request to the digit converter
    typedef struct packed {
        logic             start;
        logic             hex;
        logic [ARG_W-1:0] value;
    } t_cvt_req;

    // digit value to ascii, lower or upper case letters
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib,
                                                     input logic upper);
        logic [CHAR_W-1:0] c;
        begin
            if (nib < 4'd10) begin
                c = CH_ZERO + {4'd0, nib};
            end else if (upper) begin
                c = 8'h41 + {4'd0, nib - 4'd10};
            end else begin
                c = 8'h61 + {4'd0, nib - 4'd10};
            end
            return c;
        end
    endfunction

endpackage

// ===== src/fsip_bcd.sv =====
module fsip_bcd
    import fsip_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cvt_req i_req,
    output logic     o_busy,
    output t_digits  o_digits
);

    logic             r_busy;
    logic [STEP_W-1:0] r_step;
    logic [ARG_W-1:0] r_bin;
    t_digits          r_bcd;
    t_digits          w_adj;

    // add-3 correction on every nibble, then one shift per cycle
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                        : r_bcd[4*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_step <= '0;
            if (i_req.hex) begin
                r_busy <= 1'b0;
                r_bcd  <= t_digits'(i_req.value);
            end else begin
                r_busy <= 1'b1;
                r_bin  <= i_req.value;
                r_bcd  <= '0;
            end
        end else if (r_busy) begin
            r_bcd  <= {w_adj[BCD_W-2:0], r_bin[ARG_W-1]};
            r_bin  <= {r_bin[ARG_W-2:0], 1'b0};
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(ARG_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_digits = r_bcd;

endmodule

// ===== src/format_string_integer_printer.sv =====
// format string printer: one format character per input item, zero to ten chars out
// plain text, %c and %% load their char from S_CHAR (S_CR first for a newline)
// conversions wait in S_CONV for the converter (hex loads at once), then size the number
// then the chars follow (sign, zero pad, digits) while the sink is ready
// next item taken the cycle after the last char is registered
// reset (synchronous, active low) returns to plain text mode with pad width 0
module format_string_integer_printer
    import fsip_pkg::*;
#(
    parameter int ARG_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item: [7:0] fmt_char, [23:8] arg_value
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // result item: [7:0] out_char, tlast marks the last char of an input item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    // argument bits that take part, capped at the field width
    localparam int VAL_BITS = (ARG_BITS < ARG_W) ? ARG_BITS : ARG_W;
    localparam logic [ARG_W:0] MASK_EXT = ((ARG_W + 1)'(1) << VAL_BITS) - (ARG_W + 1)'(1);
    localparam logic [ARG_W-1:0] VAL_MASK = MASK_EXT[ARG_W-1:0];
    localparam logic SIGN_SEEN = (ARG_BITS <= ARG_W);

    typedef enum logic [1:0] {
        P_TEXT,   // plain text
        P_OPEN,   // after '%'
        P_ZERO,   // after "%0"
        P_WIDTH   // after the width character
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PCT,    // leading '%' of an unknown conversion
        S_CR,     // carriage return before a newline
        S_CHAR,   // the single final char
        S_CONV,   // waiting for the digit converter
        S_MINUS,
        S_PAD,
        S_DIG
    } t_state;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [3:0]        r_pad_width, n_pad_width;
    logic              r_cr, n_cr;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_neg, n_neg;
    logic              r_upper, n_upper;
    logic [IDX_W-1:0]  r_dig_idx, n_dig_idx;
    logic [3:0]        r_pad_cnt, n_pad_cnt;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;

    logic [CHAR_W-1:0] w_ch;
    logic [ARG_W-1:0]  w_val;
    logic              w_sign;
    logic [ARG_W-1:0]  w_neg_val;
    logic              w_accept;
    logic              w_free;
    logic              w_conv;
    logic [IDX_W:0]    w_ndig;
    logic [3:0]        w_pad_need;
    t_cvt_req          w_req;
    logic              w_bcd_busy;
    t_digits           w_digits;

    assign w_ch      = s_axis_tdata[7:0];
    assign w_val     = s_axis_tdata[23:8] & VAL_MASK;
    assign w_sign    = SIGN_SEEN && w_val[VAL_BITS-1];
    assign w_neg_val = (~w_val + 16'd1) & VAL_MASK;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // the output register can take a char this cycle
    assign w_free        = !r_out_valid || m_axis_tready;
    // this character closes a specifier
    assign w_conv = (r_phase == P_OPEN && w_ch != CH_ZERO) || (r_phase == P_WIDTH);

    // significant digits of the converted value, at least one
    always_comb begin
        priority if (w_digits[19:16] != 4'd0) begin
            w_ndig = (IDX_W + 1)'(5);
        end else if (w_digits[15:12] != 4'd0) begin
            w_ndig = (IDX_W + 1)'(4);
        end else if (w_digits[11:8] != 4'd0) begin
            w_ndig = (IDX_W + 1)'(3);
        end else if (w_digits[7:4] != 4'd0) begin
            w_ndig = (IDX_W + 1)'(2);
        end else begin
            w_ndig = (IDX_W + 1)'(1);
        end
    end

    assign w_pad_need = (r_pad_width > 4'(w_ndig)) ? r_pad_width - 4'(w_ndig) : 4'd0;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pad_width = r_pad_width;
        n_cr        = r_cr;
        n_char      = r_char;
        n_neg       = r_neg;
        n_upper     = r_upper;
        n_dig_idx   = r_dig_idx;
        n_pad_cnt   = r_pad_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_req.start = 1'b0;
        w_req.hex   = 1'b0;
        w_req.value = w_val;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_conv) begin
                        n_phase = P_TEXT;
                        // default: unknown conversion, '%' then the char
                        n_cr    = (w_ch == CH_LF);
                        n_char  = w_ch;
                        n_state = S_PCT;
                        unique case (w_ch)
                            CH_C: begin
                                n_cr    = (w_val[7:0] == CH_LF);
                                n_char  = w_val[7:0];
                                n_state = (w_val[7:0] == CH_LF) ? S_CR : S_CHAR;
                            end
                            CH_PCT: begin
                                n_cr    = 1'b0;
                                n_char  = CH_PCT;
                                n_state = S_CHAR;
                            end
                            CH_D: begin
                                w_req.start = 1'b1;
                                w_req.value = w_sign ? w_neg_val : w_val;
                                n_neg       = w_sign;
                                n_upper     = 1'b0;
                                n_state     = S_CONV;
                            end
                            CH_U: begin
                                w_req.start = 1'b1;
                                n_neg       = 1'b0;
                                n_upper     = 1'b0;
                                n_state     = S_CONV;
                            end
                            CH_XL, CH_XU: begin
                                w_req.start = 1'b1;
                                w_req.hex   = 1'b1;
                                n_neg       = 1'b0;
                                n_upper     = (w_ch == CH_XU);
                                n_state     = S_CONV;
                            end
                            default: begin
                                n_state = S_PCT;
                            end
                        endcase
                    end else begin
                        unique case (r_phase)
                            P_TEXT: begin
                                if (w_ch == CH_PCT) begin
                                    n_pad_width = 4'd0;
                                    n_phase     = P_OPEN;
                                end else begin
                                    n_cr    = (w_ch == CH_LF);
                                    n_char  = w_ch;
                                    n_state = (w_ch == CH_LF) ? S_CR : S_CHAR;
                                end
                            end
                            P_OPEN: begin
                                n_phase = P_ZERO;
                            end
                            default: begin
                                // width character, non-digits saturate to nine
                                n_pad_width = (w_ch >= CH_ZERO && w_ch <= CH_NINE)
                                              ? 4'(w_ch - CH_ZERO) : 4'd9;
                                n_phase     = P_WIDTH;
                            end
                        endcase
                    end
                end
            end
            S_PCT: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_PCT;
                    n_out_last  = 1'b0;
                    n_state     = r_cr ? S_CR : S_CHAR;
                end
            end
            S_CR: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_CR;
                    n_out_last  = 1'b0;
                    n_state     = S_CHAR;
                end
            end
            S_CHAR: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_char;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_CONV: begin
                if (!w_bcd_busy) begin
                    n_dig_idx = IDX_W'(w_ndig - 1'b1);
                    n_pad_cnt = w_pad_need;
                    if (r_neg) begin
                        n_state = S_MINUS;
                    end else if (w_pad_need != 4'd0) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_DIG;
                    end
                end
            end
            S_MINUS: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = (r_pad_cnt != 4'd0) ? S_PAD : S_DIG;
                end
            end
            S_PAD: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_ZERO;
                    n_out_last  = 1'b0;
                    n_pad_cnt   = r_pad_cnt - 4'd1;
                    if (r_pad_cnt == 4'd1) begin
                        n_state = S_DIG;
                    end
                end
            end
            S_DIG: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(w_digits[4*r_dig_idx +: 4], r_upper);
                    n_out_last  = (r_dig_idx == '0);
                    if (r_dig_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dig_idx = r_dig_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_TEXT;
            r_pad_width <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pad_width <= n_pad_width;
            r_out_valid <= n_out_valid;
        end
        r_cr       <= n_cr;
        r_char     <= n_char;
        r_neg      <= n_neg;
        r_upper    <= n_upper;
        r_dig_idx  <= n_dig_idx;
        r_pad_cnt  <= n_pad_cnt;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // shared shift-add-3 converter, also holds hex digits
    fsip_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_busy   (w_bcd_busy),
        .o_digits (w_digits)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    // pad width never beyond nine
    a_pad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_width <= 4'd9)
        else $error("pad width out of range");

    // digits are only read once the converter has finished
    a_dig_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG || r_state == S_PAD || r_state == S_MINUS) |-> !w_bcd_busy)
        else $error("digits read while converter busy");

    // converter never runs while a new item can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_bcd_busy)
        else $error("converter busy while idle");

    // a pad stage always has at least one zero left
    a_pad_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_pad_cnt != 4'd0))
        else $error("pad stage with empty count");

endmodule
